/* hw/rtl/pdd_pkg.sv */
// Shared types and constants for the PCM/float downmix decoder.
// Used by the front end, back end and top level under hw/rtl; depends on nothing else.
package pdd_pkg;

    localparam int RAW_W    = 64;
    localparam int OUT_W    = 40;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 7;
    localparam int CB_W     = 7;
    localparam int VB_W     = 6;
    localparam int CC_W     = 4;

    // Quotient bits produced per divider cycle.
    localparam int DIV_RADIX_BITS = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ENCODING  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTAINER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 3'd3;

    localparam logic ENC_PCM   = 1'b0;
    localparam logic ENC_FLOAT = 1'b1;

    typedef enum logic [1:0] {
        BK_ACC,
        BK_DIV,
        BK_OUT
    } t_back_state;

    typedef struct packed {
        logic frame_end;
        logic buffer_last;
    } t_frame_ctl;

endpackage

/* hw/rtl/pdd_fifo.sv */
// Two-entry queue between the decoding front end and the accumulating back end.
// Generic payload width; uses no package items.
module pdd_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

endmodule

/* hw/rtl/pdd_front.sv */
// Front end: input register, sample decoding (PCM or float) and frame classification.
// Depends on pdd_pkg.
module pdd_front #(
    parameter int MAX_CHANNELS  = 8,
    parameter int FRACTION_BITS = 31,
    parameter int CW            = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [pdd_pkg::RAW_W-1:0]      i_raw_sample,
    input  logic                           i_block_end,
    input  logic                           i_encoding,
    input  logic [pdd_pkg::CB_W-1:0]       i_container_bits,
    input  logic [pdd_pkg::VB_W-1:0]       i_valid_bits,
    input  logic [pdd_pkg::CC_W-1:0]       i_channel_count,
    output logic                           o_push,
    input  logic                           i_full,
    output logic signed [pdd_pkg::OUT_W-1:0] o_sample,
    output logic [CW-1:0]                  o_cnt,
    output pdd_pkg::t_frame_ctl            o_ctl
);

    localparam int PW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PCM_SHR = 31 - FRACTION_BITS;
    localparam int SHR_BASE = 1075 - FRACTION_BITS;
    localparam logic signed [pdd_pkg::OUT_W-1:0] SAT_POS =
        pdd_pkg::OUT_W'((64'd1 << (FRACTION_BITS + 8)) - 64'd1);
    localparam logic signed [pdd_pkg::OUT_W-1:0] SAT_NEG = -SAT_POS - 40'sd1;

    logic                        r_fv;
    logic [pdd_pkg::RAW_W-1:0]   r_raw;
    logic                        r_last;
    logic [PW-1:0]               r_pos;

    logic                        w_accept;
    logic [5:0]                  w_cb;
    logic [5:0]                  w_vb;
    logic [31:0]                 w_cont;
    logic [31:0]                 w_align;
    logic signed [pdd_pkg::OUT_W-1:0] w_pcm_ext;
    logic signed [pdd_pkg::OUT_W-1:0] w_pcm;
    logic                        w_neg;
    logic                        w_nonfinite;
    logic [10:0]                 w_e64;
    logic [52:0]                 w_m53;
    logic [11:0]                 w_shr;
    logic [52:0]                 w_mag;
    logic signed [pdd_pkg::OUT_W-1:0] w_flt;
    logic [CW-1:0]               w_n;
    logic [CW-1:0]               w_cnt;
    logic                        w_end;

    assign o_in_stall = r_fv & i_full;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign o_push     = r_fv & ~i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv  <= 1'b0;
            r_pos <= '0;
        end else begin
            if (w_accept) begin
                r_fv <= 1'b1;
            end else if (o_push) begin
                r_fv <= 1'b0;
            end
            if (o_push) begin
                r_pos <= w_end ? '0 : r_pos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_raw  <= i_raw_sample;
            r_last <= i_block_end;
        end
    end

    // PCM: left-justify the container in 32 bits, clear the padding, then rescale.
    always_comb begin
        if (i_container_bits == 7'd0 || i_container_bits > 7'd32) begin
            w_cb = 6'd32;
        end else begin
            w_cb = i_container_bits[5:0];
        end
        if (i_valid_bits == 6'd0 || i_valid_bits > w_cb) begin
            w_vb = w_cb;
        end else begin
            w_vb = i_valid_bits;
        end
        w_cont    = r_raw[31:0] & (32'hFFFF_FFFF >> (6'd32 - w_cb));
        w_align   = (w_cont << (6'd32 - w_cb)) & (32'hFFFF_FFFF << (6'd32 - w_vb));
        w_pcm_ext = pdd_pkg::OUT_W'($signed(w_align));
        w_pcm     = w_pcm_ext >>> PCM_SHR;
    end

    // Float: float32 is widened to the float64 layout, then one right shift truncates.
    always_comb begin
        if (i_container_bits == 7'd32) begin
            w_neg       = r_raw[31];
            w_nonfinite = (r_raw[30:23] == 8'hFF);
            if (r_raw[30:23] == 8'd0) begin
                w_e64 = 11'd897;
                w_m53 = {1'b0, r_raw[22:0], 29'd0};
            end else begin
                w_e64 = {3'd0, r_raw[30:23]} + 11'd896;
                w_m53 = {1'b1, r_raw[22:0], 29'd0};
            end
        end else begin
            w_neg       = r_raw[63];
            w_nonfinite = (r_raw[62:52] == 11'h7FF);
            if (r_raw[62:52] == 11'd0) begin
                w_e64 = 11'd1;
                w_m53 = {1'b0, r_raw[51:0]};
            end else begin
                w_e64 = r_raw[62:52];
                w_m53 = {1'b1, r_raw[51:0]};
            end
        end
        w_shr = 12'(SHR_BASE) - {1'b0, w_e64};
        w_mag = (w_shr >= 12'd53) ? 53'd0 : (w_m53 >> w_shr[5:0]);
        if (w_nonfinite) begin
            w_flt = '0;
        end else if (w_e64 >= 11'd1031) begin
            w_flt = w_neg ? SAT_NEG : SAT_POS;
        end else if (w_neg) begin
            w_flt = -$signed(w_mag[pdd_pkg::OUT_W-1:0]);
        end else begin
            w_flt = $signed(w_mag[pdd_pkg::OUT_W-1:0]);
        end
    end

    // A frame closes on its last channel or on a buffer end, whichever comes first.
    always_comb begin
        if (i_channel_count == '0) begin
            w_n = CW'(1);
        end else if (32'(i_channel_count) > MAX_CHANNELS) begin
            w_n = CW'(MAX_CHANNELS);
        end else begin
            w_n = CW'(i_channel_count);
        end
        w_cnt = CW'(r_pos) + CW'(1);
        w_end = (w_cnt >= w_n) | r_last;
    end

    assign o_sample          = (i_encoding == pdd_pkg::ENC_FLOAT) ? w_flt : w_pcm;
    assign o_cnt             = w_cnt;
    assign o_ctl.frame_end   = w_end;
    assign o_ctl.buffer_last = r_last;

endmodule

/* hw/rtl/pdd_back.sv */
// Back end: frame accumulator, radix-16 restoring divider and output register.
// Depends on pdd_pkg.
module pdd_back #(
    parameter int MAX_CHANNELS = 8,
    parameter int CW           = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    output logic                             o_pop,
    input  logic signed [pdd_pkg::OUT_W-1:0] i_sample,
    input  logic [CW-1:0]                    i_cnt,
    input  pdd_pkg::t_frame_ctl              i_ctl,
    output logic                             o_busy,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [pdd_pkg::OUT_W-1:0] o_mono_value,
    output logic                             o_buffer_last
);

    localparam int R         = pdd_pkg::DIV_RADIX_BITS;
    localparam int SUM_W     = pdd_pkg::OUT_W + $clog2(MAX_CHANNELS);
    localparam int DIV_STEPS = (SUM_W + R - 1) / R;
    localparam int PAD_W     = DIV_STEPS * R;
    localparam int SW        = $clog2(DIV_STEPS + 1);

    pdd_pkg::t_back_state r_state, n_state;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [PAD_W-1:0]        r_q, n_q;
    logic [CW-1:0]           r_rem, n_rem;
    logic [CW-1:0]           r_div, n_div;
    logic                    r_neg, n_neg;
    logic                    r_last, n_last;
    logic [SW-1:0]           r_step, n_step;
    logic                    r_ov, n_ov;
    logic signed [pdd_pkg::OUT_W-1:0] r_out, n_out;
    logic                    r_out_last, n_out_last;

    logic signed [SUM_W-1:0] v_sum;
    logic [SUM_W-1:0]        v_abs;
    logic [PAD_W-1:0]        v_q;
    logic [CW-1:0]           v_rem;
    logic [CW:0]             v_t;
    logic [pdd_pkg::OUT_W-1:0] v_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdd_pkg::BK_ACC;
            r_sum   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q        <= n_q;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_neg      <= n_neg;
        r_last     <= n_last;
        r_step     <= n_step;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state    = r_state;
        n_sum      = r_sum;
        n_q        = r_q;
        n_rem      = r_rem;
        n_div      = r_div;
        n_neg      = r_neg;
        n_last     = r_last;
        n_step     = r_step;
        n_ov       = r_ov & i_out_stall;
        n_out      = r_out;
        n_out_last = r_out_last;
        o_pop      = 1'b0;
        v_sum      = r_sum + SUM_W'(i_sample);
        v_abs      = v_sum[SUM_W-1] ? SUM_W'(-v_sum) : SUM_W'(v_sum);
        v_q        = r_q;
        v_rem      = r_rem;
        v_t        = '0;
        v_mag      = r_q[pdd_pkg::OUT_W-1:0];

        unique case (r_state)
            pdd_pkg::BK_ACC: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    if (i_ctl.frame_end) begin
                        n_sum   = '0;
                        n_neg   = v_sum[SUM_W-1];
                        n_q     = PAD_W'(v_abs);
                        n_div   = i_cnt;
                        n_rem   = '0;
                        n_step  = '0;
                        n_last  = i_ctl.buffer_last;
                        n_state = (i_cnt == CW'(1)) ? pdd_pkg::BK_OUT : pdd_pkg::BK_DIV;
                    end else begin
                        n_sum = v_sum;
                    end
                end
            end
            pdd_pkg::BK_DIV: begin
                for (int i = 0; i < R; i++) begin
                    v_t = {v_rem, v_q[PAD_W-1]};
                    v_q = {v_q[PAD_W-2:0], 1'b0};
                    if (v_t >= {1'b0, r_div}) begin
                        v_t    = v_t - {1'b0, r_div};
                        v_q[0] = 1'b1;
                    end
                    v_rem = v_t[CW-1:0];
                end
                n_q    = v_q;
                n_rem  = v_rem;
                n_step = r_step + SW'(1);
                if (r_step == SW'(DIV_STEPS - 1)) begin
                    n_state = pdd_pkg::BK_OUT;
                end
            end
            pdd_pkg::BK_OUT: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov       = 1'b1;
                    n_out      = r_neg ? -$signed(v_mag) : $signed(v_mag);
                    n_out_last = r_last;
                    n_state    = pdd_pkg::BK_ACC;
                end
            end
            default: begin
                n_state = pdd_pkg::BK_ACC;
            end
        endcase
    end

    assign o_busy        = (r_state != pdd_pkg::BK_ACC);
    assign o_out_valid   = r_ov;
    assign o_mono_value  = r_out;
    assign o_buffer_last = r_out_last;

endmodule

/* hw/rtl/pcm_float_downmix_decoder.sv */
// Top level of the PCM/float downmix decoder: configuration registers, front end,
// queue and back end. Depends on pdd_pkg, pdd_front, pdd_fifo and pdd_back.
//
// Usage: each request on the input channel carries one channel sample in its
// little-endian container (i_raw_sample) and a buffer-end flag. Samples of one
// frame are interleaved channel by channel. After the last channel of a frame,
// or at a buffer end, one request on the output channel carries the frame
// average (40-bit signed, FRACTION_BITS fraction bits) and the buffer-end flag.
// Both channels use valid/stall; an item moves when valid is high and stall low.
// The user writes the configuration registers through i_cfg_we/i_cfg_index/i_cfg_data
// only while the block is idle; the block itself does not enforce this.
// Within a frame the block takes one sample per cycle while the back end is not busy
// closing a frame: the front end registers and decodes it, and the back end adds it
// from a two-entry queue. Closing a frame loads the divider from the frame sum, runs
// the divider (skipped when the frame holds one sample) and then loads the output
// register. Reset (synchronous, active low) restores the default configuration,
// empties the frame sum and queue and clears the output valid flag. When the receiver
// stalls, the result is held, the back end waits and the queue and then input stall fill.
module pcm_float_downmix_decoder #(
    parameter int MAX_CHANNELS  = 8,
    parameter int FRACTION_BITS = 31
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [pdd_pkg::RAW_W-1:0]            i_raw_sample,
    input  logic                                 i_block_end,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [pdd_pkg::OUT_W-1:0]     o_mono_value,
    output logic                                 o_buffer_last,
    input  logic                                 i_cfg_we,
    input  logic [pdd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pdd_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam int QW = pdd_pkg::OUT_W + CW + 2;

    logic                        r_encoding;
    logic [pdd_pkg::CB_W-1:0]    r_container_bits;
    logic [pdd_pkg::VB_W-1:0]    r_valid_bits;
    logic [pdd_pkg::CC_W-1:0]    r_channel_count;

    logic                        w_push;
    logic                        w_full;
    logic signed [pdd_pkg::OUT_W-1:0] w_f_sample;
    logic [CW-1:0]               w_f_cnt;
    pdd_pkg::t_frame_ctl         w_f_ctl;
    logic                        w_pop;
    logic                        w_q_valid;
    logic [QW-1:0]               w_q_data;
    logic signed [pdd_pkg::OUT_W-1:0] w_q_sample;
    logic [CW-1:0]               w_q_cnt;
    pdd_pkg::t_frame_ctl         w_q_ctl;
    logic                        w_back_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_encoding       <= pdd_pkg::ENC_PCM;
            r_container_bits <= 7'd16;
            r_valid_bits     <= 6'd16;
            r_channel_count  <= 4'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pdd_pkg::CFG_ENCODING:  r_encoding       <= i_cfg_data[0];
                pdd_pkg::CFG_CONTAINER: r_container_bits <= i_cfg_data;
                pdd_pkg::CFG_VALID:     r_valid_bits     <= i_cfg_data[5:0];
                pdd_pkg::CFG_CHANNELS:  r_channel_count  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    pdd_front #(
        .MAX_CHANNELS  (MAX_CHANNELS),
        .FRACTION_BITS (FRACTION_BITS),
        .CW            (CW)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_raw_sample     (i_raw_sample),
        .i_block_end      (i_block_end),
        .i_encoding       (r_encoding),
        .i_container_bits (r_container_bits),
        .i_valid_bits     (r_valid_bits),
        .i_channel_count  (r_channel_count),
        .o_push           (w_push),
        .i_full           (w_full),
        .o_sample         (w_f_sample),
        .o_cnt            (w_f_cnt),
        .o_ctl            (w_f_ctl)
    );

    pdd_fifo #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_sample, w_f_cnt, w_f_ctl}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_q_sample = $signed(w_q_data[QW-1 -: pdd_pkg::OUT_W]);
    assign w_q_cnt    = w_q_data[CW+1:2];
    assign w_q_ctl    = w_q_data[1:0];

    pdd_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CW           (CW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .o_pop         (w_pop),
        .i_sample      (w_q_sample),
        .i_cnt         (w_q_cnt),
        .i_ctl         (w_q_ctl),
        .o_busy        (w_back_busy),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_mono_value  (o_mono_value),
        .o_buffer_last (o_buffer_last)
    );

    // Reset leaves no result pending and the input open.
    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output or input stall active after reset");

    // Taking a frame's closing sample must hand the frame over to the divider.
    a_frame_close : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && w_q_ctl.frame_end |=> w_back_busy)
        else $error("frame end taken without starting the average");

    // The back end takes nothing from the queue while a frame is being closed.
    a_no_pop_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_back_busy |-> !w_pop)
        else $error("queue popped while back end busy");

endmodule

/* sim/pcm_float_downmix_decoder_tb.sv */
// Self-checking testbench for pcm_float_downmix_decoder: directed and random samples
// in PCM and float modes, checked against a frame-average scoreboard.
// Depends on pdd_pkg and the pcm_float_downmix_decoder RTL.
module pcm_float_downmix_decoder_tb;

    localparam longint SAT_LIMIT  = longint'(1) <<< 39;
    localparam int     IDLE_LIMIT = 5000;
    localparam int     DRAIN_WAIT = 40;

    typedef struct {
        logic signed [pdd_pkg::OUT_W-1:0] mono;
        logic                             last;
    } t_frame_avg;

    class downmix_scoreboard;
        logic                        enc = pdd_pkg::ENC_PCM;
        logic [pdd_pkg::CB_W-1:0]    cbits = 7'd16;
        logic [pdd_pkg::VB_W-1:0]    vbits = 6'd16;
        logic [pdd_pkg::CC_W-1:0]    chans = 4'd2;
        int                          position = 0;
        longint                      sum = 0;
        t_frame_avg                  averages[$];
        int                          errors = 0;

        function void configure(logic [pdd_pkg::CFG_IDX_W-1:0] idx,
                                logic [pdd_pkg::CFG_W-1:0] data);
            case (idx)
                pdd_pkg::CFG_ENCODING:  enc = data[0];
                pdd_pkg::CFG_CONTAINER: cbits = data[pdd_pkg::CB_W-1:0];
                pdd_pkg::CFG_VALID:     vbits = data[pdd_pkg::VB_W-1:0];
                pdd_pkg::CFG_CHANNELS:  chans = data[pdd_pkg::CC_W-1:0];
                default: ;
            endcase
        endfunction

        function longint pcm_value(logic [63:0] raw);
            int          cb;
            int          vb;
            logic [63:0] w;
            longint      v;
            cb = (cbits == 0 || cbits > 32) ? 32 : cbits;
            vb = (vbits == 0 || vbits > cb) ? cb : vbits;
            w = (raw & ((64'd1 << cb) - 64'd1)) >> (cb - vb);
            v = w[vb-1] ? longint'(w) - (longint'(1) <<< vb) : longint'(w);
            return v * (longint'(1) <<< (32 - vb));
        endfunction

        function longint scaled(logic [63:0] m, int sh, bit neg, bit big);
            logic [63:0] mag;
            if (big || sh >= 64) return neg ? -SAT_LIMIT : SAT_LIMIT - 1;
            if (sh >= 0) mag = m << sh;
            else if (sh <= -64) mag = 64'd0;
            else mag = m >> (-sh);
            if (mag >= 64'(SAT_LIMIT)) return neg ? -SAT_LIMIT : SAT_LIMIT - 1;
            return neg ? -longint'(mag) : longint'(mag);
        endfunction

        function longint float_value(logic [63:0] raw);
            int          e;
            logic [63:0] m;
            if (cbits == 7'd32) begin
                e = raw[30:23];
                m = {41'd0, raw[22:0]};
                if (e == 255) return 0;
                if (e == 0) e = 1; else m[23] = 1'b1;
                return scaled(m, e - 150 + 31, raw[31], e >= 135);
            end
            e = raw[62:52];
            m = {12'd0, raw[51:0]};
            if (e == 2047) return 0;
            if (e == 0) e = 1; else m[52] = 1'b1;
            return scaled(m, e - 1075 + 31, raw[63], e >= 1031);
        endfunction

        function void note_sample(logic [63:0] raw, logic last);
            int         n;
            longint     avg;
            t_frame_avg exp_avg;
            n = (chans == 0) ? 1 : (chans > 8) ? 8 : chans;
            sum += (enc == pdd_pkg::ENC_FLOAT) ? float_value(raw) : pcm_value(raw);
            if (position + 1 >= n || last) begin
                avg = sum / longint'(position + 1);
                exp_avg.mono = avg[pdd_pkg::OUT_W-1:0];
                exp_avg.last = last;
                averages.push_back(exp_avg);
                position = 0;
                sum = 0;
            end else begin
                position++;
            end
        endfunction

        function void check_result(logic signed [pdd_pkg::OUT_W-1:0] mono, logic last);
            t_frame_avg e;
            if (averages.size() == 0) begin
                $display("%0t: unexpected result mono=%h last=%b", $time, mono, last);
                errors++;
                return;
            end
            e = averages.pop_front();
            if (mono !== e.mono) begin
                $display("%0t: mono_value expected %h actual %h", $time, e.mono, mono);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: buffer_last expected %b actual %b", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_stall;
    logic [pdd_pkg::RAW_W-1:0]        i_raw_sample = '0;
    logic                             i_block_end = 1'b0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic signed [pdd_pkg::OUT_W-1:0] o_mono_value;
    logic                             o_buffer_last;
    logic                             i_cfg_we = 1'b0;
    logic [pdd_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [pdd_pkg::CFG_W-1:0]        i_cfg_data = '0;

    downmix_scoreboard sb = new();
    bit hold_long = 0;
    int idle_cycles = 0;

    pcm_float_downmix_decoder dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stall before each request, one long hold-off on demand.
    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            gap = hold_long ? 400 : $urandom_range(0, 5);
            hold_long = 0;
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_mono_value, o_buffer_last);
        end
    end

    task automatic send_sample(logic [63:0] raw, logic last);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_raw_sample <= raw;
        i_block_end  <= last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(raw, last);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.averages.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(logic [pdd_pkg::CFG_IDX_W-1:0] idx,
                             logic [pdd_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.configure(idx, data);
    endtask

    task automatic set_mode(logic enc, int cb, int vb, int cc);
        drain();
        write_reg(pdd_pkg::CFG_ENCODING, pdd_pkg::CFG_W'(enc));
        write_reg(pdd_pkg::CFG_CONTAINER, pdd_pkg::CFG_W'(cb));
        write_reg(pdd_pkg::CFG_VALID, pdd_pkg::CFG_W'(vb));
        write_reg(pdd_pkg::CFG_CHANNELS, pdd_pkg::CFG_W'(cc));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] random_raw(logic enc, int cb);
        logic [63:0] r;
        int          e;
        r = {$urandom, $urandom};
        if (enc == pdd_pkg::ENC_PCM || $urandom_range(0, 9) == 0) return r;
        if (cb == 32) begin
            e = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(100, 140);
            r[30:23] = e[7:0];
        end else begin
            e = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(990, 1035);
            r[62:52] = e[10:0];
        end
        return r;
    endfunction

    initial begin
        int n_items;
        int cb;
        logic enc;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: PCM 16 bits, two channels; extremes and bits above the container.
        send_sample(64'h7FFF, 1'b0);
        send_sample(64'h7FFF, 1'b0);
        send_sample(64'hFFFF_FFFF_FFFF_8000, 1'b0);
        send_sample(64'h8000, 1'b0);
        send_sample(64'h1234, 1'b1);
        // Channel count lowered while a frame is open.
        set_mode(pdd_pkg::ENC_PCM, 24, 20, 3);
        send_sample(64'h80_0000, 1'b0);
        set_mode(pdd_pkg::ENC_PCM, 32, 32, 1);
        send_sample(64'h8000_0000, 1'b0);
        send_sample(64'h7FFF_FFFF, 1'b0);
        set_mode(pdd_pkg::ENC_PCM, 0, 0, 0);
        send_sample(64'hFFFF_FFFF, 1'b0);
        set_mode(pdd_pkg::ENC_PCM, 40, 1, 15);
        send_sample(64'hFFFF_FFFF, 1'b0);
        send_sample(64'h7FFF_FFFF, 1'b1);
        set_mode(pdd_pkg::ENC_PCM, 16, 32, 8);
        send_sample(64'h8001, 1'b1);
        // Float32: one, saturation, largest below the limit, specials, subnormal.
        set_mode(pdd_pkg::ENC_FLOAT, 32, 16, 1);
        send_sample(64'h3F80_0000, 1'b0);
        send_sample(64'hC380_0000, 1'b0);
        send_sample(64'h4380_0000, 1'b0);
        send_sample(64'h437F_FFFF, 1'b0);
        send_sample(64'h7F80_0000, 1'b0);
        send_sample(64'hFFC0_0000, 1'b0);
        send_sample(64'h8000_0001, 1'b0);
        // Float64, also via an odd container width.
        set_mode(pdd_pkg::ENC_FLOAT, 64, 16, 2);
        send_sample(64'h3FF0_0000_0000_0000, 1'b0);
        send_sample(64'hFFF0_0000_0000_0000, 1'b0);
        send_sample(64'h0000_0000_0000_0001, 1'b0);
        send_sample(64'hC070_0000_0000_0000, 1'b0);
        set_mode(pdd_pkg::ENC_FLOAT, 16, 16, 1);
        send_sample(64'h406F_FFFF_FFFF_FFFF, 1'b0);

        for (int phase = 0; phase < 30; phase++) begin
            enc = $urandom_range(0, 1);
            if (enc == pdd_pkg::ENC_PCM) begin
                case ($urandom_range(0, 7))
                    0: cb = $urandom_range(0, 127);
                    1, 2: cb = 16;
                    3, 4: cb = 24;
                    default: cb = 32;
                endcase
            end else begin
                cb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                 : ($urandom_range(0, 1) ? 32 : 64);
            end
            set_mode(enc, cb, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                         : $urandom_range(1, 32),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(1, 8));
            if (phase == 5) hold_long = 1;
            n_items = 30;
            for (int k = 0; k < n_items; k++) begin
                send_sample(random_raw(enc, cb), $urandom_range(0, 11) == 0);
            end
        end

        drain();
        if (sb.errors == 0 && sb.averages.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/pdd_pkg.sv
hw/rtl/pdd_fifo.sv
hw/rtl/pdd_front.sv
hw/rtl/pdd_back.sv
hw/rtl/pcm_float_downmix_decoder.sv
sim/pcm_float_downmix_decoder_tb.sv
